// ===== rtl/core/csvt_pkg.sv =====
package csvt_pkg;

    // default size of the trailing whitespace buffer
    localparam int PENDING_DEPTH_DEF = 16;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // parse position within the current field
    typedef enum logic [2:0] {
        MODE_START   = 3'd0,
        MODE_QUOTED  = 3'd1,
        MODE_QSEEN   = 3'd2,
        MODE_SWALLOW = 3'd3,
        MODE_DATA    = 3'd4
    } t_mode;

    // transfer sequencer
    typedef enum logic [1:0] {
        SEQ_ACCEPT = 2'd0,
        SEQ_FLUSH  = 2'd1,
        SEQ_TAIL   = 2'd2
    } t_seq;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_AFTER_CLOSE = 3'd1,
        ERR_STRAY_QUOTE = 3'd2,
        ERR_UNTERMINATED = 3'd3,
        ERR_OVERFLOW    = 3'd4
    } t_err;

    // source of the output byte
    typedef enum logic [1:0] {
        OSEL_ITEM = 2'd0,
        OSEL_PEND = 2'd1,
        OSEL_HOLD = 2'd2
    } t_osel;

    typedef struct packed {
        logic byte_valid;
        logic field_done;
        logic row_done;
        logic field_quoted;
        t_err err;
        logic last;
    } t_result;

    typedef struct packed {
        logic    load_out;
        t_osel   osel;
        t_result res;
        logic    push;
        logic    clr_cnt;
        logic    hold_load;
        logic    idx_inc;
        logic    idx_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic count_zero;
        logic count_full;
        logic flush_last;
    } t_dp_sts;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

// ===== rtl/core/csvt_dp.sv =====
module csvt_dp #(
    parameter int PENDING_DEPTH = csvt_pkg::PENDING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_line_byte,
    input  logic              i_stall,
    input  csvt_pkg::t_dp_cmd i_cmd,
    output csvt_pkg::t_dp_sts o_sts,
    output logic              o_valid,
    output logic [7:0]        o_field_byte,
    output csvt_pkg::t_result o_res
);
    import csvt_pkg::*;

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    logic [7:0]       mem [PENDING_DEPTH];
    logic [7:0]       r_rd_data;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [7:0]       r_hold;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [7:0]       n_out_byte;
    t_result          r_out_res;

    always_comb begin
        n_count = r_count;
        if (i_cmd.clr_cnt) begin
            n_count = '0;
        end else if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    always_comb begin
        unique case (i_cmd.osel)
            OSEL_PEND: n_out_byte = r_rd_data;
            OSEL_HOLD: n_out_byte = r_hold;
            default:   n_out_byte = i_cmd.res.byte_valid ? i_line_byte : 8'h00;
        endcase
    end

    // pending whitespace buffer, read address follows the next index
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_count[IDX_W-1:0]] <= i_line_byte;
        end
        r_rd_data <= mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_load) begin
            r_hold <= i_line_byte;
        end
        if (i_cmd.load_out) begin
            r_out_byte <= n_out_byte;
            r_out_res  <= i_cmd.res;
        end
    end

    assign o_sts.slot_free  = !r_out_valid || !i_stall;
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.count_full = (r_count >= CNT_W'(PENDING_DEPTH));
    assign o_sts.flush_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    assign o_valid      = r_out_valid;
    assign o_field_byte = r_out_byte;
    assign o_res        = r_out_res;

endmodule

// ===== rtl/core/csvt_ctrl.sv =====
module csvt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_line_byte,
    input  logic              i_end_of_line,
    input  csvt_pkg::t_dp_sts i_sts,
    output logic              o_stall,
    output csvt_pkg::t_dp_cmd o_cmd
);
    import csvt_pkg::*;

    t_seq    r_seq;
    t_seq    n_seq;
    t_mode   r_mode;
    t_mode   n_mode;
    logic    r_nonempty;
    logic    n_nonempty;
    logic    acc;
    logic    is_sp;

    // per-item decode
    logic    d_has_res;
    t_result d_res;
    t_mode   d_mode;
    logic    d_nonempty;
    logic    d_push;
    logic    d_clr;
    logic    d_flush;

    assign acc   = i_valid && (r_seq == SEQ_ACCEPT) && i_sts.slot_free;
    assign is_sp = is_space(i_line_byte);

    always_comb begin
        d_has_res  = 1'b0;
        d_res      = '0;
        d_res.err  = ERR_NONE;
        d_res.last = 1'b1;
        d_mode     = r_mode;
        d_nonempty = r_nonempty;
        d_push     = 1'b0;
        d_clr      = 1'b0;
        d_flush    = 1'b0;
        unique case (r_mode)
            MODE_SWALLOW: begin
                if (i_end_of_line) begin
                    d_mode     = MODE_START;
                    d_nonempty = 1'b0;
                    d_clr      = 1'b1;
                end
            end
            MODE_QUOTED: begin
                if (i_end_of_line) begin
                    d_has_res       = 1'b1;
                    d_res.row_done  = 1'b1;
                    d_res.err       = ERR_UNTERMINATED;
                    d_mode          = MODE_SWALLOW;
                    d_nonempty      = 1'b0;
                    d_clr           = 1'b1;
                end else if (i_line_byte == CH_QUOTE) begin
                    d_mode = MODE_QSEEN;
                end else begin
                    d_has_res        = 1'b1;
                    d_res.byte_valid = 1'b1;
                end
            end
            MODE_QSEEN: begin
                if (i_end_of_line || i_line_byte == CH_COMMA) begin
                    d_has_res          = 1'b1;
                    d_res.field_done   = 1'b1;
                    d_res.row_done     = i_end_of_line;
                    d_res.field_quoted = 1'b1;
                    d_mode             = MODE_START;
                    d_nonempty         = 1'b0;
                    d_clr              = 1'b1;
                end else if (i_line_byte == CH_QUOTE) begin
                    d_has_res        = 1'b1;
                    d_res.byte_valid = 1'b1;
                    d_mode           = MODE_QUOTED;
                end else begin
                    d_has_res      = 1'b1;
                    d_res.row_done = 1'b1;
                    d_res.err      = ERR_AFTER_CLOSE;
                    d_mode         = MODE_SWALLOW;
                    d_nonempty     = 1'b0;
                    d_clr          = 1'b1;
                end
            end
            MODE_DATA: begin
                if (i_end_of_line || i_line_byte == CH_COMMA) begin
                    d_has_res        = 1'b1;
                    d_res.field_done = 1'b1;
                    d_res.row_done   = i_end_of_line;
                    d_mode           = MODE_START;
                    d_nonempty       = 1'b0;
                    d_clr            = 1'b1;
                end else if (i_line_byte == CH_QUOTE || (is_sp && i_sts.count_full)) begin
                    d_has_res      = 1'b1;
                    d_res.row_done = 1'b1;
                    d_res.err      = (i_line_byte == CH_QUOTE) ? ERR_STRAY_QUOTE
                                                               : ERR_OVERFLOW;
                    d_mode         = MODE_SWALLOW;
                    d_nonempty     = 1'b0;
                    d_clr          = 1'b1;
                end else if (is_sp) begin
                    d_push = 1'b1;
                end else if (i_sts.count_zero) begin
                    d_has_res        = 1'b1;
                    d_res.byte_valid = 1'b1;
                end else begin
                    d_flush = 1'b1;
                end
            end
            default: begin
                if (i_end_of_line || i_line_byte == CH_COMMA) begin
                    d_has_res        = 1'b1;
                    d_res.field_done = 1'b1;
                    d_res.row_done   = i_end_of_line;
                    d_mode           = MODE_START;
                    d_nonempty       = 1'b0;
                    d_clr            = 1'b1;
                end else if (i_line_byte == CH_QUOTE) begin
                    if (r_nonempty) begin
                        d_has_res      = 1'b1;
                        d_res.row_done = 1'b1;
                        d_res.err      = ERR_STRAY_QUOTE;
                        d_mode         = MODE_SWALLOW;
                        d_nonempty     = 1'b0;
                        d_clr          = 1'b1;
                    end else begin
                        d_mode = MODE_QUOTED;
                    end
                end else if (is_sp) begin
                    d_mode     = MODE_START;
                    d_nonempty = 1'b1;
                end else begin
                    d_has_res        = 1'b1;
                    d_res.byte_valid = 1'b1;
                    d_mode           = MODE_DATA;
                    d_nonempty       = 1'b1;
                    d_clr            = 1'b1;
                end
            end
        endcase
    end

    // next state
    always_comb begin
        n_seq      = r_seq;
        n_mode     = r_mode;
        n_nonempty = r_nonempty;
        unique case (r_seq)
            SEQ_ACCEPT: begin
                if (acc) begin
                    n_mode     = d_mode;
                    n_nonempty = d_nonempty;
                    if (d_flush) begin
                        n_seq = SEQ_FLUSH;
                    end
                end
            end
            SEQ_FLUSH: begin
                if (i_sts.slot_free && i_sts.flush_last) begin
                    n_seq = SEQ_TAIL;
                end
            end
            SEQ_TAIL: begin
                if (i_sts.slot_free) begin
                    n_seq = SEQ_ACCEPT;
                end
            end
            default: begin
                n_seq = SEQ_ACCEPT;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.osel       = OSEL_ITEM;
        o_cmd.res.err    = ERR_NONE;
        o_stall          = 1'b1;
        unique case (r_seq)
            SEQ_ACCEPT: begin
                o_stall         = !i_sts.slot_free;
                o_cmd.load_out  = acc && d_has_res;
                o_cmd.res       = d_res;
                o_cmd.push      = acc && d_push;
                o_cmd.clr_cnt   = acc && d_clr;
                o_cmd.hold_load = acc && d_flush;
            end
            SEQ_FLUSH: begin
                o_cmd.load_out       = i_sts.slot_free;
                o_cmd.osel           = OSEL_PEND;
                o_cmd.res.byte_valid = 1'b1;
                o_cmd.res.last       = 1'b0;
                o_cmd.idx_inc        = i_sts.slot_free && !i_sts.flush_last;
                o_cmd.idx_clr        = i_sts.slot_free && i_sts.flush_last;
            end
            SEQ_TAIL: begin
                o_cmd.load_out       = i_sts.slot_free;
                o_cmd.osel           = OSEL_HOLD;
                o_cmd.res.byte_valid = 1'b1;
                o_cmd.res.last       = 1'b1;
                o_cmd.clr_cnt        = i_sts.slot_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= SEQ_ACCEPT;
            r_mode     <= MODE_START;
            r_nonempty <= 1'b0;
        end else begin
            r_seq      <= n_seq;
            r_mode     <= n_mode;
            r_nonempty <= n_nonempty;
        end
    end

endmodule

// ===== rtl/core/csv_field_tokenizer_core.sv =====
// csv field tokenizer: takes one byte of a csv line per transfer (or an
// end-of-line mark) and returns field content bytes, a field close result per
// field and a row close result, with rfc 4180 style quoting. quoted fields are
// kept verbatim and a doubled quote gives one quote; unquoted fields lose
// leading and trailing space, tab, cr and lf. whitespace inside an unquoted
// field waits in a pending buffer of PENDING_DEPTH bytes until a later
// non-space byte of the same field arrives. errors (text after a closing
// quote, stray quote, unterminated quote, pending buffer overflow) close the
// row with o_row_done and o_error_kind set, and the rest of the line (for an
// unterminated quote, all the next line) is dropped up to its end-of-line
// mark. rate: one transfer per cycle while results are taken; a byte that
// frees buffered whitespace holds the input while those bytes, then itself,
// go out, as the buffer memory gives one byte per cycle. o_last_of_run flags
// the last result of a transfer. the buffer needs no clearing after reset.
module csv_field_tokenizer_core #(
    parameter int PENDING_DEPTH = csvt_pkg::PENDING_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input bytes
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_line_byte,
    input  logic       i_end_of_line,
    // results
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_field_byte,
    output logic       o_byte_valid,
    output logic       o_field_done,
    output logic       o_row_done,
    output logic       o_field_quoted,
    output logic [2:0] o_error_kind,
    output logic       o_last_of_run
);
    import csvt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_result res;

    // controller: parse mode, per-transfer decode and the flush sequencer
    csvt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_line_byte   (i_line_byte),
        .i_end_of_line (i_end_of_line),
        .i_sts         (sts),
        .o_stall       (o_stall),
        .o_cmd         (cmd)
    );

    // datapath: pending whitespace memory, counters and the output register
    csvt_dp #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_byte  (i_line_byte),
        .i_stall      (i_stall),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_field_byte (o_field_byte),
        .o_res        (res)
    );

    assign o_byte_valid   = res.byte_valid;
    assign o_field_done   = res.field_done;
    assign o_row_done     = res.row_done;
    assign o_field_quoted = res.field_quoted;
    assign o_error_kind   = res.err;
    assign o_last_of_run  = res.last;

endmodule

// ===== rtl/core/csvt_checker.sv =====
module csvt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_field_byte,
    input logic       o_byte_valid,
    input logic       o_field_done,
    input logic       o_row_done,
    input logic       o_field_quoted,
    input logic [2:0] o_error_kind,
    input logic       o_last_of_run
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_field_byte)
            && $stable(o_last_of_run) && $stable(o_error_kind))
        else $error("stalled result changed");

    // a content byte never closes anything
    a_byte_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_valid |-> !o_field_done && !o_row_done
            && !o_field_quoted && o_error_kind == 3'd0)
        else $error("content byte carries close or error");

    // an error closes the row and ends the run
    a_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_kind != 3'd0 |-> o_row_done && !o_field_done
            && o_last_of_run && o_field_byte == 8'h00)
        else $error("bad error result");

    // a close result ends the run, and quoted only marks a closed field
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_last_of_run && o_field_byte == 8'h00
            && (o_field_done || !o_field_quoted))
        else $error("bad close result");

endmodule

bind csv_field_tokenizer_core csvt_checker u_csvt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_field_byte   (o_field_byte),
    .o_byte_valid   (o_byte_valid),
    .o_field_done   (o_field_done),
    .o_row_done     (o_row_done),
    .o_field_quoted (o_field_quoted),
    .o_error_kind   (o_error_kind),
    .o_last_of_run  (o_last_of_run)
);
